/* sv/spdl_pkg.sv */
package spdl_pkg;

    localparam int unsigned MAX_LINE_DEF = 7;

    localparam logic [15:0] PERIOD_RST = 16'd20000;
    localparam logic [14:0] MIN_PULSE_RST = 15'd1000;
    localparam logic [14:0] SPAN_RST = 15'd1000;
    localparam logic [15:0] WIDTH_RST = 16'd1000;
    localparam logic [15:0] PHASE_RST = PERIOD_RST - WIDTH_RST;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam int unsigned CFG_AW = 2;
    localparam int unsigned CFG_DW = 16;

    typedef enum logic [CFG_AW-1:0] {
        REG_PERIOD = 2'd0,
        REG_MIN_PULSE = 2'd1,
        REG_SPAN = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } spdl_in_t;

    typedef struct packed {
        logic        servo_level;
        logic        done_res;
        logic [15:0] pulse_width;
    } spdl_out_t;

    typedef struct packed {
        logic              we;
        logic [CFG_AW-1:0] addr;
        logic [CFG_DW-1:0] data;
    } spdl_cfg_wr_t;

endpackage

/* sv/servo_pulse_from_decimal_lines.sv */
// Servo pulse generator driven by decimal text lines.
//
// Input channel (in_valid/in_ready/in_data): each transfer is either a received
// serial byte (action 0) or one microsecond tick (action 1). Bytes build a line
// ended by CR, LF or the MAX_LINE-th byte; its decimal value, clamped to
// pulse_span and offset by min_pulse, becomes the new pulse width.
// Output channel (out_valid/out_ready/out_data): exactly one result transfer
// per input transfer, in order: servo level, line-done flag, pulse width.
// Configuration: cfg_we/cfg_addr/cfg_data write period_ticks (0), min_pulse (1)
// and pulse_span (2); other indices are dropped.
//
// The result of an input transfer is registered in the output register, or in
// the skid register when the output is stalled. One item per cycle while
// in_ready is high, set by the single state-update stage in spdl_core.
// A two-entry output buffer (output register plus skid register) lets one more
// input transfer be taken after out_ready drops; in_ready falls while the skid
// register is full.
// Reset: both buffer entries empty, registers at their defaults (20000, 1000,
// 1000), width 1000, pin low for 19000 ticks before the first high phase.
module servo_pulse_from_decimal_lines
    import spdl_pkg::*;
#(
    parameter int unsigned MAX_LINE = MAX_LINE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  spdl_in_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output spdl_out_t         out_data
);

    spdl_cfg_wr_t cfg;
    spdl_out_t    result;
    logic         in_xfer;
    logic         out_xfer;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    spdl_out_t out_data_reg, out_data_next;
    spdl_out_t skid_data_reg, skid_data_next;

    assign cfg = '{we: cfg_we, addr: cfg_addr, data: cfg_data};

    spdl_core #(
        .MAX_LINE(MAX_LINE)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (in_xfer),
        .item   (in_data),
        .result (result)
    );

    assign in_ready = !skid_valid_reg;
    assign in_xfer = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next = out_data_reg;
        skid_data_next = skid_data_reg;
        if (out_xfer || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_xfer;
                out_data_next = result;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_next = 1'b1;
            skid_data_next = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with output empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("stalled transfer not captured in skid");

    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not drained");

endmodule

/* sv/spdl_core.sv */
module spdl_core
    import spdl_pkg::*;
#(
    parameter int unsigned MAX_LINE = MAX_LINE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  spdl_cfg_wr_t cfg,
    input  logic         step,
    input  spdl_in_t     item,
    output spdl_out_t    result
);

    localparam int unsigned LEN_W = $clog2(MAX_LINE + 1);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LINE);

    logic [15:0]      period_reg;
    logic [14:0]      min_pulse_reg;
    logic [14:0]      span_reg;

    logic [15:0]      value_reg, value_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      cmd_reg, cmd_next;
    logic             pin_reg, pin_next;
    logic [15:0]      phase_reg, phase_next;
    logic [15:0]      active_reg, active_next;
    logic             done;

    logic [15:0] digit_value;
    logic [15:0] clamped;
    logic [LEN_W-1:0] len_inc;
    logic        is_digit;
    logic        line_end;
    logic [15:0] low_cur;
    logic [15:0] low_cmd;

    always_comb
    begin
        low_cur = (period_reg > active_reg) ? period_reg - active_reg : 16'd0;
        low_cmd = (period_reg > cmd_reg) ? period_reg - cmd_reg : 16'd0;

        is_digit = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);
        digit_value = {value_reg[12:0], 3'b000} + {value_reg[14:0], 1'b0}
                    + {12'd0, item.rx_byte[3:0]};
        len_inc = len_reg + LEN_W'(1);
        line_end = (item.rx_byte == CHAR_CR) || (item.rx_byte == CHAR_LF)
                 || (len_inc >= LEN_LAST);

        value_next = value_reg;
        len_next = len_reg;
        cmd_next = cmd_reg;
        pin_next = pin_reg;
        phase_next = phase_reg;
        active_next = active_reg;
        done = 1'b0;
        clamped = 16'd0;

        if (item.action)
        begin
            if (phase_reg > 16'd1)
            begin
                phase_next = phase_reg - 16'd1;
            end
            else if (pin_reg && (low_cur != 16'd0))
            begin
                pin_next = 1'b0;
                phase_next = low_cur;
            end
            else
            begin
                // start of a new period, width sampled here; a zero width keeps the pin low
                active_next = cmd_reg;
                if (cmd_reg != 16'd0)
                begin
                    pin_next = 1'b1;
                    phase_next = cmd_reg;
                end
                else
                begin
                    pin_next = 1'b0;
                    phase_next = (low_cmd != 16'd0) ? low_cmd : 16'd1;
                end
            end
        end
        else
        begin
            if (is_digit)
            begin
                value_next = digit_value;
            end
            len_next = len_inc;
            if (line_end)
            begin
                clamped = (value_next > {1'b0, span_reg}) ? {1'b0, span_reg} : value_next;
                cmd_next = clamped + {1'b0, min_pulse_reg};
                value_next = 16'd0;
                len_next = '0;
                done = 1'b1;
            end
        end

        result.servo_level = pin_next;
        result.done_res = done;
        result.pulse_width = cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            min_pulse_reg <= MIN_PULSE_RST;
            span_reg <= SPAN_RST;
            value_reg <= 16'd0;
            len_reg <= '0;
            cmd_reg <= WIDTH_RST;
            pin_reg <= 1'b0;
            phase_reg <= PHASE_RST;
            active_reg <= WIDTH_RST;
        end
        else
        begin
            if (cfg.we)
            begin
                unique case (cfg.addr)
                    REG_PERIOD:    period_reg <= cfg.data;
                    REG_MIN_PULSE: min_pulse_reg <= cfg.data[14:0];
                    REG_SPAN:      span_reg <= cfg.data[14:0];
                    default:       ;
                endcase
            end
            if (step)
            begin
                value_reg <= value_next;
                len_reg <= len_next;
                cmd_reg <= cmd_next;
                pin_reg <= pin_next;
                phase_reg <= phase_next;
                active_reg <= active_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg < LEN_LAST))
        else $error("line length past limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.done_res) |=> (value_reg == 16'd0) && (len_reg == '0))
        else $error("line state not cleared at line end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != 16'd0))
        else $error("phase counter reached zero");

endmodule
